// ----- src/dpae_pkg.sv -----
package dpae_pkg;

    localparam int WordW    = 32;
    localparam int RegCount = 16;
    localparam int RegIdxW  = $clog2(RegCount);
    localparam int FuncW    = 4;
    localparam int OperandW = 12;
    localparam int FlagsW   = 4;
    localparam int AmtW     = 8;

    typedef logic [WordW-1:0]    word_t;
    typedef logic [RegIdxW-1:0]  reg_idx_t;
    typedef logic [FuncW-1:0]    func_t;
    typedef logic [OperandW-1:0] operand_t;
    typedef logic [FlagsW-1:0]   flags_t;
    typedef logic [AmtW-1:0]     amt_t;

    // Operation codes.
    localparam func_t FUNC_AND = 4'd0;
    localparam func_t FUNC_EOR = 4'd1;
    localparam func_t FUNC_SUB = 4'd2;
    localparam func_t FUNC_RSB = 4'd3;
    localparam func_t FUNC_ADD = 4'd4;
    localparam func_t FUNC_TST = 4'd8;
    localparam func_t FUNC_TEQ = 4'd9;
    localparam func_t FUNC_CMP = 4'd10;
    localparam func_t FUNC_ORR = 4'd12;
    localparam func_t FUNC_MOV = 4'd13;

    // Shift types in the register form of the second operand.
    localparam logic [1:0] SHIFT_LSL = 2'd0;
    localparam logic [1:0] SHIFT_LSR = 2'd1;
    localparam logic [1:0] SHIFT_ASR = 2'd2;
    localparam logic [1:0] SHIFT_ROR = 2'd3;

    // Bit positions in the NZCV flag register.
    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    typedef struct packed {
        word_t op2;
        logic  carry;
    } shift_result_t;

    typedef struct packed {
        logic   written;
        word_t  value;
        flags_t flags;
        logic   unsupported;
    } alu_result_t;

endpackage

// ----- src/dpae_if.sv -----
interface dpae_instr_if;
    import dpae_pkg::*;

    logic     valid;
    logic     ready;
    func_t    func;
    logic     imm_flag;
    logic     set_flags;
    reg_idx_t rn_index;
    reg_idx_t rd_index;
    operand_t operand_field;

    modport source (
        output valid, func, imm_flag, set_flags, rn_index, rd_index, operand_field,
        input  ready
    );
    modport sink (
        input  valid, func, imm_flag, set_flags, rn_index, rd_index, operand_field,
        output ready
    );
endinterface

interface dpae_result_if;
    import dpae_pkg::*;

    logic   valid;
    logic   ready;
    logic   dest_written;
    word_t  dest_value;
    flags_t flags_nzcv;
    logic   unsupported;

    modport source (
        output valid, dest_written, dest_value, flags_nzcv, unsupported,
        input  ready
    );
    modport sink (
        input  valid, dest_written, dest_value, flags_nzcv, unsupported,
        output ready
    );
endinterface

// ----- src/dpae_ram.sv -----
module dpae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Registered read; a read at the address being written returns the old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/dpae_shifter.sv -----
module dpae_shifter (
    input  logic                    imm_flag,
    input  dpae_pkg::operand_t      operand_field,
    input  dpae_pkg::word_t         rm,
    input  dpae_pkg::word_t         rs,
    input  logic                    carry_in,
    output dpae_pkg::shift_result_t res
);
    import dpae_pkg::*;

    logic [4:0]          rot;
    word_t               imm_word;
    logic [2*WordW-1:0]  imm_wide;
    amt_t                amt;
    logic [2*WordW-1:0]  ror_wide;
    logic [WordW:0]      lsl_wide;
    logic [WordW:0]      lsr_wide;
    logic signed [WordW:0] asr_wide;
    logic                big_amt;

    always_comb
    begin
        rot      = {operand_field[11:8], 1'b0};
        imm_word = {{(WordW-8){1'b0}}, operand_field[7:0]};
        imm_wide = {imm_word, imm_word} >> rot;

        amt = operand_field[4] ? rs[AmtW-1:0] : {3'b000, operand_field[11:7]};
        big_amt  = (amt[AmtW-1:5] != '0);
        ror_wide = {rm, rm} >> amt[4:0];
        lsl_wide = {1'b0, rm} << amt[4:0];
        lsr_wide = {rm, 1'b0} >> amt[4:0];
        asr_wide = $signed({rm, 1'b0}) >>> amt[4:0];

        res = '0;
        if (imm_flag)
        begin
            res.op2   = imm_wide[WordW-1:0];
            res.carry = (rot != '0) ? imm_wide[WordW-1] : carry_in;
        end
        else if (amt == '0)
        begin
            res.op2   = rm;
            res.carry = carry_in;
        end
        else
        begin
            case (operand_field[6:5])
                SHIFT_LSL:
                begin
                    if (!big_amt)
                    begin
                        res.op2   = lsl_wide[WordW-1:0];
                        res.carry = lsl_wide[WordW];
                    end
                    else
                    begin
                        res.op2   = '0;
                        res.carry = (amt == AmtW'(WordW)) ? rm[0] : 1'b0;
                    end
                end
                SHIFT_LSR:
                begin
                    if (!big_amt)
                    begin
                        res.op2   = lsr_wide[WordW:1];
                        res.carry = lsr_wide[0];
                    end
                    else
                    begin
                        res.op2   = '0;
                        res.carry = (amt == AmtW'(WordW)) ? rm[WordW-1] : 1'b0;
                    end
                end
                SHIFT_ASR:
                begin
                    if (!big_amt)
                    begin
                        res.op2   = asr_wide[WordW:1];
                        res.carry = asr_wide[0];
                    end
                    else
                    begin
                        res.op2   = {WordW{rm[WordW-1]}};
                        res.carry = rm[WordW-1];
                    end
                end
                default:
                begin
                    // Rotation by a multiple of the word size leaves the value in place.
                    res.op2   = ror_wide[WordW-1:0];
                    res.carry = ror_wide[WordW-1];
                end
            endcase
        end
    end

endmodule

// ----- src/dpae_alu.sv -----
module dpae_alu (
    input  dpae_pkg::func_t         func,
    input  logic                    set_flags,
    input  dpae_pkg::word_t         op1,
    input  dpae_pkg::shift_result_t shift,
    input  dpae_pkg::flags_t        flags_in,
    output dpae_pkg::alu_result_t   res
);
    import dpae_pkg::*;

    logic [WordW:0] sum;
    word_t          value;
    logic           carry;
    logic           supported;

    always_comb
    begin
        supported = (func inside {FUNC_AND, FUNC_EOR, FUNC_SUB, FUNC_RSB, FUNC_ADD,
                                  FUNC_TST, FUNC_TEQ, FUNC_CMP, FUNC_ORR, FUNC_MOV});
        sum   = '0;
        value = '0;
        carry = shift.carry;
        case (func)
            FUNC_AND, FUNC_TST:
            begin
                value = op1 & shift.op2;
            end
            FUNC_EOR, FUNC_TEQ:
            begin
                value = op1 ^ shift.op2;
            end
            FUNC_SUB, FUNC_CMP:
            begin
                // Carry out of the subtraction means no borrow.
                sum   = {1'b0, op1} + {1'b0, ~shift.op2} + (WordW+1)'(1);
                value = sum[WordW-1:0];
                carry = sum[WordW];
            end
            FUNC_RSB:
            begin
                sum   = {1'b0, shift.op2} + {1'b0, ~op1} + (WordW+1)'(1);
                value = sum[WordW-1:0];
                carry = sum[WordW];
            end
            FUNC_ADD:
            begin
                sum   = {1'b0, op1} + {1'b0, shift.op2};
                value = sum[WordW-1:0];
                carry = sum[WordW];
            end
            FUNC_ORR:
            begin
                value = op1 | shift.op2;
            end
            FUNC_MOV:
            begin
                value = shift.op2;
            end
            default:
            begin
                value = '0;
            end
        endcase

        res             = '0;
        res.unsupported = !supported;
        res.value       = value;
        res.written     = supported && !(func inside {FUNC_TST, FUNC_TEQ, FUNC_CMP});
        res.flags       = flags_in;
        if (supported && set_flags)
        begin
            res.flags[FLAG_N] = value[WordW-1];
            res.flags[FLAG_Z] = (value == '0);
            res.flags[FLAG_C] = carry;
            res.flags[FLAG_V] = flags_in[FLAG_V];
        end
    end

endmodule

// ----- src/data_processing_alu_execute.sv -----
// An accepted item is held in the execute stage and then in the result register.
// Throughput: one item per cycle unless the result side stalls; the register
// read at accept and the single-pass shift and ALU stage behind it run every cycle.
// Reset clears the pipeline valids, the NZCV flags and the register-valid bits,
// so every register reads as zero until it is first written.
module data_processing_alu_execute (
    input  logic          clk,
    input  logic          rst_n,
    dpae_instr_if.sink    instr,
    dpae_result_if.source result
);
    import dpae_pkg::*;

    // Execute stage: item fields captured at accept. The register file copies
    // return Rn, Rm and Rs in their read registers, captured alongside these.
    logic     s1_valid_reg;
    logic     s1_valid_next;
    func_t    s1_func_reg;
    logic     s1_imm_flag_reg;
    logic     s1_set_flags_reg;
    reg_idx_t s1_rn_reg;
    reg_idx_t s1_rd_reg;
    operand_t s1_operand_reg;

    // Result register on the output side.
    logic        out_valid_reg;
    logic        out_valid_next;
    alu_result_t out_reg;

    // Architectural state. The register file lives in three copies of one RAM
    // so that three operands can be read in the same cycle; every write goes to
    // all three. A valid bit per register stands in for clearing at reset.
    flags_t              flags_reg;
    logic [RegCount-1:0] reg_valid_reg;

    // The most recent register write. An item accepted in the same cycle as
    // that write reads stale RAM data, so the execute stage takes this instead.
    logic     byp_valid_reg;
    reg_idx_t byp_idx_reg;
    word_t    byp_value_reg;

    logic          accept;
    logic          s1_fire;
    logic          wr_en;
    word_t         rn_q;
    word_t         rm_q;
    word_t         rs_q;
    word_t         op1;
    word_t         rm_val;
    word_t         rs_val;
    shift_result_t shift_res;
    alu_result_t   alu_res;

    function automatic word_t read_operand(
        input reg_idx_t            idx,
        input word_t               ram_q,
        input logic                byp_valid,
        input reg_idx_t            byp_idx,
        input word_t               byp_value,
        input logic [RegCount-1:0] valid_bits
    );
        word_t v;
        if (byp_valid && (byp_idx == idx))
        begin
            v = byp_value;
        end
        else if (valid_bits[idx])
        begin
            v = ram_q;
        end
        else
        begin
            v = '0;
        end
        return v;
    endfunction

    // Handshake: the execute stage moves on whenever the result register is
    // empty or being drained, and a new item enters behind it in the same cycle.
    assign s1_fire      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign instr.ready  = !s1_valid_reg || s1_fire;
    assign accept       = instr.valid && instr.ready;
    assign wr_en        = s1_fire && alu_res.written;

    dpae_ram #(.WIDTH(WordW), .DEPTH(RegCount)) u_ram_rn (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_rd_reg),
        .wdata (alu_res.value),
        .re    (accept),
        .raddr (instr.rn_index),
        .rdata (rn_q)
    );

    dpae_ram #(.WIDTH(WordW), .DEPTH(RegCount)) u_ram_rm (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_rd_reg),
        .wdata (alu_res.value),
        .re    (accept),
        .raddr (instr.operand_field[3:0]),
        .rdata (rm_q)
    );

    dpae_ram #(.WIDTH(WordW), .DEPTH(RegCount)) u_ram_rs (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_rd_reg),
        .wdata (alu_res.value),
        .re    (accept),
        .raddr (instr.operand_field[11:8]),
        .rdata (rs_q)
    );

    always_comb
    begin
        op1    = read_operand(s1_rn_reg, rn_q, byp_valid_reg, byp_idx_reg,
                              byp_value_reg, reg_valid_reg);
        rm_val = read_operand(s1_operand_reg[3:0], rm_q, byp_valid_reg, byp_idx_reg,
                              byp_value_reg, reg_valid_reg);
        rs_val = read_operand(s1_operand_reg[11:8], rs_q, byp_valid_reg, byp_idx_reg,
                              byp_value_reg, reg_valid_reg);
    end

    dpae_shifter u_shifter (
        .imm_flag      (s1_imm_flag_reg),
        .operand_field (s1_operand_reg),
        .rm            (rm_val),
        .rs            (rs_val),
        .carry_in      (flags_reg[FLAG_C]),
        .res           (shift_res)
    );

    dpae_alu u_alu (
        .func      (s1_func_reg),
        .set_flags (s1_set_flags_reg),
        .op1       (op1),
        .shift     (shift_res),
        .flags_in  (flags_reg),
        .res       (alu_res)
    );

    always_comb
    begin
        s1_valid_next = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            reg_valid_reg <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                flags_reg <= alu_res.flags;
            end
            if (wr_en)
            begin
                reg_valid_reg[s1_rd_reg] <= 1'b1;
                byp_valid_reg            <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg      <= instr.func;
            s1_imm_flag_reg  <= instr.imm_flag;
            s1_set_flags_reg <= instr.set_flags;
            s1_rn_reg        <= instr.rn_index;
            s1_rd_reg        <= instr.rd_index;
            s1_operand_reg   <= instr.operand_field;
        end
        if (s1_fire)
        begin
            out_reg <= alu_res;
        end
        if (wr_en)
        begin
            byp_idx_reg   <= s1_rd_reg;
            byp_value_reg <= alu_res.value;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.dest_written = out_reg.written;
    assign result.dest_value   = out_reg.value;
    assign result.flags_nzcv   = out_reg.flags;
    assign result.unsupported  = out_reg.unsupported;

endmodule

// ----- tb/tb_data_processing_alu_execute.sv -----
module tb_data_processing_alu_execute;
    timeunit 1ns;
    timeprecision 1ps;

    import dpae_pkg::*;

    // Run shape. The cycle limit is far above the slowest legal run: about 780 items,
    // each with the longest send gap, the longest result stall and the pipeline latency.
    localparam int ITEM_COUNT   = 750;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_WAIT     = 17;
    localparam int HALF_PERIOD  = 6;

    // The ten operations the block implements, used to pick random supported items.
    localparam func_t ALU_OPS [10] = '{FUNC_AND, FUNC_EOR, FUNC_SUB, FUNC_RSB, FUNC_ADD,
                                       FUNC_TST, FUNC_TEQ, FUNC_CMP, FUNC_ORR, FUNC_MOV};

    // One instruction item as it crosses the input channel.
    typedef struct packed {
        func_t    func;
        logic     imm_flag;
        logic     set_flags;
        reg_idx_t rn_index;
        reg_idx_t rd_index;
        operand_t operand_field;
    } instr_item_t;

    // The scoreboard keeps its own copy of the register file and the NZCV flags.
    // Every accepted instruction is executed here at once, in acceptance order, and
    // the outcome is queued until the block delivers the matching result item.
    class dp_exec_scoreboard;
        word_t       regs [RegCount];
        flags_t      nzcv;
        alu_result_t pending_results [$];
        int          errors;
        int          items_seen;
        int          results_checked;
        int          reg_writes;
        int          unsupported_seen;

        function new();
            foreach (regs[i])
                regs[i] = '0;
            nzcv             = '0;
            errors           = 0;
            items_seen       = 0;
            results_checked  = 0;
            reg_writes       = 0;
            unsupported_seen = 0;
        endfunction

        static function bit supported(func_t f);
            return f inside {FUNC_AND, FUNC_EOR, FUNC_SUB, FUNC_RSB, FUNC_ADD,
                             FUNC_TST, FUNC_TEQ, FUNC_CMP, FUNC_ORR, FUNC_MOV};
        endfunction

        function word_t rotate_right(word_t v, int r);
            int k;
            k = r % WordW;
            if (k == 0)
                return v;
            return (v >> k) | (v << (WordW - k));
        endfunction

        // Barrel shifter with the carry rules of the register form. A zero amount passes
        // the value through with the current carry.
        function shift_result_t barrel_shift(word_t v, logic [1:0] kind, amt_t amt,
                                             logic cin);
            shift_result_t s;
            int            n;
            n       = int'(amt);
            s.op2   = v;
            s.carry = cin;
            if (n == 0)
                return s;
            case (kind)
                SHIFT_LSL:
                begin
                    if (n < WordW)
                    begin
                        s.op2   = v << n;
                        s.carry = v[WordW - n];
                    end
                    else
                    begin
                        s.op2   = '0;
                        s.carry = (n == WordW) ? v[0] : 1'b0;
                    end
                end
                SHIFT_LSR:
                begin
                    if (n < WordW)
                    begin
                        s.op2   = v >> n;
                        s.carry = v[n - 1];
                    end
                    else
                    begin
                        s.op2   = '0;
                        s.carry = (n == WordW) ? v[WordW-1] : 1'b0;
                    end
                end
                SHIFT_ASR:
                begin
                    if (n < WordW)
                    begin
                        s.op2   = word_t'($signed(v) >>> n);
                        s.carry = v[n - 1];
                    end
                    else
                    begin
                        s.op2   = {WordW{v[WordW-1]}};
                        s.carry = v[WordW-1];
                    end
                end
                default:
                begin
                    // Multiples of 32 leave the value as it is; the carry is still bit 31.
                    s.op2   = rotate_right(v, n);
                    s.carry = s.op2[WordW-1];
                end
            endcase
            return s;
        endfunction

        // Executes one accepted instruction and queues the result item it must produce.
        function void note_instr(instr_item_t it);
            alu_result_t    expected;
            word_t          op1;
            word_t          op2;
            word_t          res;
            shift_result_t  sh;
            logic [WordW:0] sum;
            logic           carry;
            int             rot;
            amt_t           amt;
            bit             writes_rd;
            items_seen++;
            expected = '0;
            if (!supported(it.func))
            begin
                expected.flags       = nzcv;
                expected.unsupported = 1'b1;
                unsupported_seen++;
                pending_results.push_back(expected);
                return;
            end

            // All operands are read before the destination is written.
            op1   = regs[it.rn_index];
            carry = nzcv[FLAG_C];
            if (it.imm_flag)
            begin
                rot = 2 * int'(it.operand_field[11:8]);
                op2 = rotate_right(word_t'(it.operand_field[7:0]), rot);
                if (rot != 0)
                    carry = op2[WordW-1];
            end
            else
            begin
                if (it.operand_field[4])
                    amt = regs[it.operand_field[11:8]][AmtW-1:0];
                else
                    amt = amt_t'(it.operand_field[11:7]);
                sh    = barrel_shift(regs[it.operand_field[3:0]], it.operand_field[6:5],
                                     amt, carry);
                op2   = sh.op2;
                carry = sh.carry;
            end

            case (it.func)
                FUNC_AND, FUNC_TST: res = op1 & op2;
                FUNC_EOR, FUNC_TEQ: res = op1 ^ op2;
                FUNC_SUB, FUNC_CMP:
                begin
                    res   = op1 - op2;
                    carry = (op1 >= op2);
                end
                FUNC_RSB:
                begin
                    res   = op2 - op1;
                    carry = (op2 >= op1);
                end
                FUNC_ADD:
                begin
                    sum   = {1'b0, op1} + {1'b0, op2};
                    res   = sum[WordW-1:0];
                    carry = sum[WordW];
                end
                FUNC_ORR: res = op1 | op2;
                default:  res = op2;
            endcase

            writes_rd = !(it.func inside {FUNC_TST, FUNC_TEQ, FUNC_CMP});
            if (writes_rd)
            begin
                regs[it.rd_index] = res;
                reg_writes++;
            end
            // V is never touched by these operations.
            if (it.set_flags)
            begin
                nzcv[FLAG_N] = res[WordW-1];
                nzcv[FLAG_Z] = (res == '0);
                nzcv[FLAG_C] = carry;
            end

            expected.written = writes_rd;
            expected.value   = res;
            expected.flags   = nzcv;
            pending_results.push_back(expected);
        endfunction

        function void check_result(alu_result_t got);
            alu_result_t expected;
            if (pending_results.size() == 0)
            begin
                $error("result item with nothing outstanding: value %h flags %b",
                       got.value, got.flags);
                errors++;
                return;
            end
            expected = pending_results.pop_front();
            results_checked++;
            if (got.written !== expected.written)
            begin
                $error("dest_written: expected %0b, got %0b", expected.written, got.written);
                errors++;
            end
            if (got.value !== expected.value)
            begin
                $error("dest_value: expected %h, got %h", expected.value, got.value);
                errors++;
            end
            if (got.flags !== expected.flags)
            begin
                $error("flags_nzcv: expected %b, got %b", expected.flags, got.flags);
                errors++;
            end
            if (got.unsupported !== expected.unsupported)
            begin
                $error("unsupported: expected %0b, got %0b", expected.unsupported,
                       got.unsupported);
                errors++;
            end
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n;
    int unsigned   cycle_count = 0;
    int            sent_count = 0;
    bit            sender_calm = 1'b0;
    alu_result_t   got_result;
    instr_item_t   got_instr;

    dp_exec_scoreboard sb = new();

    dpae_instr_if  instr_bus ();
    dpae_result_if result_bus ();

    data_processing_alu_execute dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_bus),
        .result (result_bus)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding", CYCLE_LIMIT,
                     sb.pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Both channels are sampled at the rising edge, before any of that edge's updates.
    // A result never leaves in the same cycle its instruction enters, so checking
    // before noting the new item keeps the queue in order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                got_result = '{written:     result_bus.dest_written,
                               value:       result_bus.dest_value,
                               flags:       result_bus.flags_nzcv,
                               unsupported: result_bus.unsupported};
                sb.check_result(got_result);
            end
            if (instr_bus.valid && instr_bus.ready)
            begin
                got_instr = '{func:          instr_bus.func,
                              imm_flag:      instr_bus.imm_flag,
                              set_flags:     instr_bus.set_flags,
                              rn_index:      instr_bus.rn_index,
                              rd_index:      instr_bus.rd_index,
                              operand_field: instr_bus.operand_field};
                sb.note_instr(got_instr);
            end
        end
    end

    // Second-operand encodings.
    function automatic operand_t imm_operand(logic [3:0] rot, logic [7:0] imm8);
        return {rot, imm8};
    endfunction

    function automatic operand_t const_shift(reg_idx_t rm, logic [1:0] kind,
                                             logic [4:0] amt);
        return {amt, kind, 1'b0, rm};
    endfunction

    function automatic operand_t reg_shift(reg_idx_t rm, logic [1:0] kind, reg_idx_t rs,
                                           logic bit7);
        return {rs, bit7, kind, 1'b1, rm};
    endfunction

    // Drives one instruction item. The task is entered on a falling edge and returns on
    // the falling edge after acceptance. Every 32 items the sender picks either a run
    // with no gaps or a run with random gaps bounded by MAX_WAIT.
    task automatic issue(func_t f, logic imm, logic setf, reg_idx_t rn, reg_idx_t rd,
                         operand_t opf);
        int gap;
        if (sent_count % 32 == 0)
            sender_calm = ($urandom_range(0, 2) == 0);
        gap = sender_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            instr_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        instr_bus.valid         <= 1'b1;
        instr_bus.func          <= f;
        instr_bus.imm_flag      <= imm;
        instr_bus.set_flags     <= setf;
        instr_bus.rn_index      <= rn;
        instr_bus.rd_index      <= rd;
        instr_bus.operand_field <= opf;
        do
            @(posedge clk);
        while (!instr_bus.ready);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic run_directed();
        // Registers: r1 holds the sign bit alone, r2/r3/r4 the amounts 32, 33 and 64.
        issue(FUNC_MOV, 1'b1, 1'b1, 4'd0, 4'd1, imm_operand(4'd1, 8'h02));
        // A zero rotate leaves C as it was.
        issue(FUNC_MOV, 1'b1, 1'b1, 4'd0, 4'd2, imm_operand(4'd0, 8'd32));
        issue(FUNC_MOV, 1'b1, 1'b0, 4'd0, 4'd3, imm_operand(4'd0, 8'd33));
        issue(FUNC_MOV, 1'b1, 1'b0, 4'd0, 4'd4, imm_operand(4'd0, 8'd64));
        // Zero minus one: all ones with a borrow, then an ADD that carries out.
        issue(FUNC_SUB, 1'b1, 1'b1, 4'd0, 4'd5, imm_operand(4'd0, 8'd1));
        issue(FUNC_ADD, 1'b0, 1'b1, 4'd5, 4'd6, const_shift(4'd5, SHIFT_LSL, 5'd0));
        // Register amounts of 32 and above, for every shift type.
        issue(FUNC_MOV, 1'b0, 1'b1, 4'd0, 4'd7, reg_shift(4'd5, SHIFT_LSL, 4'd2, 1'b0));
        issue(FUNC_MOV, 1'b0, 1'b1, 4'd0, 4'd8, reg_shift(4'd1, SHIFT_LSR, 4'd2, 1'b0));
        issue(FUNC_MOV, 1'b0, 1'b1, 4'd0, 4'd8, reg_shift(4'd5, SHIFT_LSR, 4'd3, 1'b0));
        issue(FUNC_MOV, 1'b0, 1'b1, 4'd0, 4'd7, reg_shift(4'd5, SHIFT_LSL, 4'd3, 1'b0));
        issue(FUNC_MOV, 1'b0, 1'b1, 4'd0, 4'd9, reg_shift(4'd1, SHIFT_ASR, 4'd3, 1'b0));
        issue(FUNC_MOV, 1'b0, 1'b1, 4'd0, 4'd9, reg_shift(4'd1, SHIFT_ROR, 4'd4, 1'b0));
        issue(FUNC_MOV, 1'b0, 1'b1, 4'd0, 4'd10, reg_shift(4'd1, SHIFT_ROR, 4'd3, 1'b0));
        // A register amount of zero passes the operand and the carry through.
        issue(FUNC_MOV, 1'b0, 1'b1, 4'd0, 4'd10, reg_shift(4'd5, SHIFT_LSL, 4'd0, 1'b0));
        // Bit 7 must be ignored in the register-amount form.
        issue(FUNC_ORR, 1'b0, 1'b1, 4'd1, 4'd11, reg_shift(4'd6, SHIFT_LSR, 4'd2, 1'b1));
        // Largest rotate of the largest immediate.
        issue(FUNC_MOV, 1'b1, 1'b1, 4'd0, 4'd12, operand_t'('1));
        issue(FUNC_RSB, 1'b1, 1'b1, 4'd1, 4'd13, imm_operand(4'd0, 8'd0));
        issue(FUNC_EOR, 1'b0, 1'b1, 4'd5, 4'd14, const_shift(4'd1, SHIFT_ASR, 5'd31));
        // Register 15 behaves like any other register.
        issue(FUNC_ADD, 1'b0, 1'b1, 4'd12, 4'd15, const_shift(4'd5, SHIFT_LSR, 5'd31));
        issue(FUNC_TST, 1'b1, 1'b1, 4'd15, 4'd0, imm_operand(4'd0, 8'hFF));
        issue(FUNC_TEQ, 1'b0, 1'b1, 4'd1, 4'd0, const_shift(4'd1, SHIFT_LSL, 5'd0));
        issue(FUNC_CMP, 1'b0, 1'b1, 4'd5, 4'd0, const_shift(4'd6, SHIFT_ROR, 5'd31));
        // All-ones register form: r15 rotated by the low byte of r15.
        issue(FUNC_MOV, 1'b0, 1'b1, 4'd15, 4'd0, operand_t'('1));
        // Every unsupported code, with flag updates requested that must not happen.
        for (int code = 0; code < 16; code++)
        begin
            if (!dp_exec_scoreboard::supported(func_t'(code)))
                issue(func_t'(code), 1'($urandom_range(0, 1)), 1'b1, reg_idx_t'($urandom),
                      reg_idx_t'($urandom), operand_t'($urandom));
        end
    endtask

    // Random traffic. Small immediates loaded into random registers give the
    // register-amount shifts their zero, in-range and 32-and-above cases; most items
    // are supported operations with random fields, and a few are fully random.
    task automatic run_random();
        int sel;
        for (int i = 0; i < ITEM_COUNT; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 15)
                issue(FUNC_MOV, 1'b1, 1'($urandom_range(0, 1)), reg_idx_t'($urandom),
                      reg_idx_t'($urandom), imm_operand(4'd0, 8'($urandom_range(0, 70))));
            else if (sel < 23)
                issue(func_t'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      reg_idx_t'($urandom), reg_idx_t'($urandom), operand_t'($urandom));
            else
                issue(ALU_OPS[$urandom_range(0, 9)], 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), reg_idx_t'($urandom), reg_idx_t'($urandom),
                      operand_t'($urandom));
        end
    endtask

    // Result side: a fresh stall per result item, with calm stretches of no stalls.
    initial
    begin : result_sink
        int stall;
        int taken;
        bit calm;
        result_bus.ready = 1'b0;
        taken = 0;
        calm  = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (taken % 40 == 0)
                calm = ($urandom_range(0, 2) == 0);
            stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_bus.valid);
            taken++;
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        rst_n                   = 1'b0;
        instr_bus.valid         = 1'b0;
        instr_bus.func          = FUNC_AND;
        instr_bus.imm_flag      = 1'b0;
        instr_bus.set_flags     = 1'b0;
        instr_bus.rn_index      = '0;
        instr_bus.rd_index      = '0;
        instr_bus.operand_field = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        run_random();
        instr_bus.valid <= 1'b0;

        // Wait for every outstanding result, then for a drain period so that a
        // spurious extra result item would still be caught.
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d instructions (%0d unsupported), checked %0d results,",
                 sb.items_seen, sb.unsupported_seen, sb.results_checked);
        $display("with %0d register writes and %0d mismatches.", sb.reg_writes, sb.errors);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/dpae_pkg.sv
src/dpae_if.sv
src/dpae_ram.sv
src/dpae_shifter.sv
src/dpae_alu.sv
src/data_processing_alu_execute.sv
tb/tb_data_processing_alu_execute.sv
